// ===== src/tosp_pkg.sv =====
// Shared types and constants for the TCP option stream parser.
package tosp_pkg;
    localparam int MAX_SACK_BLOCKS = 4;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [1:0] PH_KIND = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [7:0] K_EOL   = 8'd0;
    localparam logic [7:0] K_NOP   = 8'd1;
    localparam logic [7:0] K_MSS   = 8'd2;
    localparam logic [7:0] K_WS    = 8'd3;
    localparam logic [7:0] K_SACKP = 8'd4;
    localparam logic [7:0] K_SACK  = 8'd5;
    localparam logic [7:0] K_TS    = 8'd8;

    localparam logic [6:0] MAX_OPT_RESET = 7'd40;
    localparam logic [6:0] MAX_OPT_CAP   = 7'd64;
    localparam logic [0:0] REG_MAX_OPTIONS = 1'b0;

    // one beat of the front/back queue: up to two results caused by one byte
    typedef struct packed {
        logic        rec_valid;
        logic [7:0]  kind;
        logic [7:0]  length;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [1:0]  block_index;
        logic [2:0]  block_count;
        logic [6:0]  rec_count;
        logic        stat_valid;
        logic        status_code;
        logic [6:0]  stat_count;
    } tosp_job_t;
endpackage

// ===== src/tosp_front.sv =====
// Front end: parses option bytes and classifies the results each byte causes.
module tosp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [6:0]          max_options,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    output tosp_pkg::tosp_job_t job,
    output logic                job_valid,
    input  logic                job_ready
);
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  bio_reg, bio_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  sbn_reg, sbn_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        stop_reg, stop_next;
    logic        err_reg, err_next;
    logic [6:0]  lim;
    logic        bad;
    logic [7:0]  lm2;
    logic        done;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign lim = (max_options > tosp_pkg::MAX_OPT_CAP) ? tosp_pkg::MAX_OPT_CAP : max_options;
    assign lm2 = in_byte - 8'd2;

    always_comb begin
        if (in_byte < 8'd2) begin
            bad = 1'b1;
        end else begin
            case (kind_reg)
                tosp_pkg::K_MSS:   bad = in_byte != 8'd4;
                tosp_pkg::K_WS:    bad = in_byte != 8'd3;
                tosp_pkg::K_SACKP: bad = in_byte != 8'd2;
                tosp_pkg::K_TS:    bad = in_byte != 8'd10;
                tosp_pkg::K_SACK:  bad = (lm2[2:0] != 3'd0) ||
                                         (lm2[7:3] > 5'(tosp_pkg::MAX_SACK_BLOCKS));
                default:           bad = 1'b0;
            endcase
        end
    end

    always_comb begin
        logic [7:0] bn;
        logic [7:0] bm2;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        bio_next   = bio_reg;
        shift_next = shift_reg;
        sbn_next   = sbn_reg;
        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        done       = 1'b0;
        bn         = bio_reg + 8'd1;
        bm2        = bn - 8'd2;
        job = '0;
        job.rec_count = cnt_reg + 7'd1;
        if (!stop_reg) begin
            case (phase_reg)
                tosp_pkg::PH_KIND: begin
                    if (cnt_reg >= lim || in_byte == tosp_pkg::K_EOL) begin
                        stop_next = 1'b1;
                    end else if (in_byte == tosp_pkg::K_NOP) begin
                        job.rec_valid = 1'b1;
                        job.kind      = tosp_pkg::K_NOP;
                        job.length    = 8'd1;
                        cnt_next      = cnt_reg + 7'd1;
                    end else begin
                        kind_next  = in_byte;
                        len_next   = 8'd0;
                        bio_next   = 8'd1;
                        shift_next = '0;
                        sbn_next   = 3'd0;
                        phase_next = tosp_pkg::PH_LEN;
                    end
                end
                tosp_pkg::PH_LEN: begin
                    len_next = in_byte;
                    bio_next = 8'd2;
                    if (bad) begin
                        err_next  = 1'b1;
                        stop_next = 1'b1;
                    end else if (in_byte == 8'd2) begin
                        job.rec_valid = kind_reg != tosp_pkg::K_SACK;
                        job.kind      = kind_reg;
                        job.length    = 8'd2;
                        cnt_next      = cnt_reg + 7'd1;
                        phase_next    = tosp_pkg::PH_KIND;
                    end else begin
                        phase_next = tosp_pkg::PH_BODY;
                    end
                end
                default: begin
                    shift_next = {shift_reg[55:0], in_byte};
                    bio_next   = bn;
                    done       = bn == len_reg;
                    job.kind   = kind_reg;
                    job.length = len_reg;
                    if (kind_reg == tosp_pkg::K_SACK) begin
                        if (bm2[2:0] == 3'd0) begin
                            job.rec_valid    = 1'b1;
                            job.first_value  = shift_next[63:32];
                            job.second_value = shift_next[31:0];
                            job.block_index  = sbn_reg[1:0];
                            job.block_count  = 3'((len_reg - 8'd2) >> 3);
                            sbn_next         = sbn_reg + 3'd1;
                        end
                    end else if (done) begin
                        job.rec_valid = 1'b1;
                        case (kind_reg)
                            tosp_pkg::K_MSS: job.first_value = {16'd0, shift_next[15:0]};
                            tosp_pkg::K_WS:  job.first_value = {24'd0, shift_next[7:0]};
                            tosp_pkg::K_TS: begin
                                job.first_value  = shift_next[63:32];
                                job.second_value = shift_next[31:0];
                            end
                            default: ;
                        endcase
                    end
                    if (done) begin
                        cnt_next   = cnt_reg + 7'd1;
                        phase_next = tosp_pkg::PH_KIND;
                    end
                end
            endcase
            if (in_last && !stop_next && phase_next != tosp_pkg::PH_KIND) begin
                err_next  = 1'b1;
                stop_next = 1'b1;
            end
        end
        if (in_last) begin
            job.stat_valid  = 1'b1;
            job.status_code = err_next;
            job.stat_count  = cnt_next;
            phase_next = tosp_pkg::PH_KIND;
            kind_next  = '0;
            len_next   = '0;
            bio_next   = '0;
            shift_next = '0;
            sbn_next   = '0;
            cnt_next   = '0;
            stop_next  = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tosp_pkg::PH_KIND;
            kind_reg  <= '0;
            len_reg   <= '0;
            bio_reg   <= '0;
            shift_reg <= '0;
            sbn_reg   <= '0;
            cnt_reg   <= '0;
            stop_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else if (in_valid && job_ready) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            bio_reg   <= bio_next;
            shift_reg <= shift_next;
            sbn_reg   <= sbn_next;
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
        end
    end
endmodule

// ===== src/tosp_queue.sv =====
// Short FIFO of classified jobs between the front and back ends.
module tosp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  tosp_pkg::tosp_job_t wr_job,
    output logic                rd_valid,
    input  logic                rd_ready,
    output tosp_pkg::tosp_job_t rd_job
);
    tosp_pkg::tosp_job_t mem_reg [tosp_pkg::QDEPTH];
    logic [tosp_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [tosp_pkg::QAW:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 3'(tosp_pkg::QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 3'd1 : 3'd0) - (rd ? 3'd1 : 3'd0);
        end
    end
endmodule

// ===== src/tosp_back.sv =====
// Back end: emits the record and status beats of each queued job.
module tosp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  tosp_pkg::tosp_job_t job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_status,
    output logic [7:0]          m_kind,
    output logic [7:0]          m_length,
    output logic [31:0]         m_first_value,
    output logic [31:0]         m_second_value,
    output logic [1:0]          m_block_index,
    output logic [2:0]          m_block_count,
    output logic                m_status_code,
    output logic [6:0]          m_option_count,
    output logic                m_end_of_run
);
    logic rec_done_reg;
    logic any, send_stat, fire;

    assign any       = job.rec_valid || job.stat_valid;
    assign send_stat = !job.rec_valid || rec_done_reg;
    assign m_valid   = job_valid && any;
    assign fire      = m_valid && m_ready;
    assign job_ready = !any || (fire && (send_stat || !job.stat_valid));

    always_comb begin
        m_is_status    = send_stat;
        m_kind         = send_stat ? 8'd0 : job.kind;
        m_length       = send_stat ? 8'd0 : job.length;
        m_first_value  = send_stat ? 32'd0 : job.first_value;
        m_second_value = send_stat ? 32'd0 : job.second_value;
        m_block_index  = send_stat ? 2'd0 : job.block_index;
        m_block_count  = send_stat ? 3'd0 : job.block_count;
        m_status_code  = send_stat ? job.status_code : 1'b0;
        m_option_count = send_stat ? job.stat_count : job.rec_count;
        m_end_of_run   = send_stat || !job.stat_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_done_reg <= 1'b0;
        end else if (job_valid && job_ready) begin
            rec_done_reg <= 1'b0;
        end else if (fire && !send_stat) begin
            rec_done_reg <= 1'b1;
        end
    end
endmodule

// ===== src/tcp_option_stream_parser.sv =====
// Top level of the TCP option stream parser.
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid/s_ready   | s_option_byte, s_last_byte
//  m_      | out | m_valid/m_ready   | ten result fields
//  apb     | in  | psel/penable      | max_options at address 0
// One byte is accepted per cycle while the job queue has room; each byte makes at most two result beats.
// A byte with both an option record and the status gives a record beat, then a status beat.
// A four-entry job queue decouples parsing from output stalls.
// Reset is synchronous, active low, and clears parse state; max_options becomes 40.
module tcp_option_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_option_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_kind,
    output logic [7:0]  m_length,
    output logic [31:0] m_first_value,
    output logic [31:0] m_second_value,
    output logic [1:0]  m_block_index,
    output logic [2:0]  m_block_count,
    output logic        m_status_code,
    output logic [6:0]  m_option_count,
    output logic        m_end_of_run
);
    logic [6:0] max_reg;
    tosp_pkg::tosp_job_t fjob, bjob;
    logic fvalid, fready, bvalid, bready;

    assign pready = 1'b1;
    assign prdata = (paddr == tosp_pkg::REG_MAX_OPTIONS) ? {25'd0, max_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= tosp_pkg::MAX_OPT_RESET;
        end else if (psel && penable && pwrite && paddr == tosp_pkg::REG_MAX_OPTIONS) begin
            max_reg <= pwdata[6:0];
        end
    end

    tosp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .max_options(max_reg),
        .in_valid(s_valid), .in_byte(s_option_byte), .in_last(s_last_byte),
        .in_ready(s_ready), .job(fjob), .job_valid(fvalid), .job_ready(fready)
    );

    tosp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(fvalid), .wr_ready(fready),
        .wr_job(fjob), .rd_valid(bvalid), .rd_ready(bready), .rd_job(bjob)
    );

    tosp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(bvalid), .job_ready(bready),
        .job(bjob), .m_valid(m_valid), .m_ready(m_ready),
        .m_is_status(m_is_status), .m_kind(m_kind), .m_length(m_length),
        .m_first_value(m_first_value), .m_second_value(m_second_value),
        .m_block_index(m_block_index), .m_block_count(m_block_count),
        .m_status_code(m_status_code), .m_option_count(m_option_count),
        .m_end_of_run(m_end_of_run)
    );
endmodule

// ===== src/tosp_checker.sv =====
// Port-level assertions for the TCP option stream parser, bound to the top level.
module tosp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_is_status,
    input logic        m_end_of_run,
    input logic        m_status_code,
    input logic [7:0]  m_kind,
    input logic [6:0]  m_option_count
);
    a_status_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_end_of_run)
        else $error("status beat without end_of_run");
    a_status_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_kind == 8'd0)
        else $error("status beat with nonzero kind");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_option_count <= 7'd64)
        else $error("option count above 64");
    a_rec_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |-> !m_status_code)
        else $error("record beat with status code");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("result beat dropped while stalled");
endmodule

bind tcp_option_stream_parser tosp_checker u_tosp_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_is_status(m_is_status), .m_end_of_run(m_end_of_run),
    .m_status_code(m_status_code), .m_kind(m_kind), .m_option_count(m_option_count)
);

// ===== test/tcp_option_stream_parser_tb.sv =====
// Testbench for the TCP option stream parser: random and directed option areas against a predictor.
`timescale 1ns / 1ps
module tcp_option_stream_parser_tb;
    import tosp_pkg::*;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  kind;
        logic [7:0]  length;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [1:0]  block_index;
        logic [2:0]  block_count;
        logic        status_code;
        logic [6:0]  option_count;
        logic        end_of_run;
    } opt_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_option_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_status;
    logic [7:0]  m_kind;
    logic [7:0]  m_length;
    logic [31:0] m_first_value;
    logic [31:0] m_second_value;
    logic [1:0]  m_block_index;
    logic [2:0]  m_block_count;
    logic        m_status_code;
    logic [6:0]  m_option_count;
    logic        m_end_of_run;

    tcp_option_stream_parser u_top (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [6:0]  opt_limit;
    logic [1:0]  phase;
    logic [7:0]  cur_kind;
    logic [7:0]  cur_len;
    logic [7:0]  byte_pos;
    logic [63:0] acc;
    logic [2:0]  sack_num;
    logic [6:0]  opt_cnt;
    logic        halted;
    logic        err_flag;

    opt_result_t expected_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    logic        hold_active = 1'b0;
    event        hold_go;
    int          mismatches = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;
    int          areas_sent = 0;

    function automatic void clear_area();
        phase = PH_KIND; cur_kind = '0; cur_len = '0; byte_pos = '0;
        acc = '0; sack_num = '0; opt_cnt = '0; halted = 1'b0; err_flag = 1'b0;
    endfunction

    function automatic bit length_bad(logic [7:0] k, logic [7:0] l);
        if (l < 8'd2) return 1'b1;
        case (k)
            K_MSS:   return l != 8'd4;
            K_WS:    return l != 8'd3;
            K_SACKP: return l != 8'd2;
            K_TS:    return l != 8'd10;
            K_SACK:  return ((l - 8'd2) & 8'd7) != 8'd0 || (l - 8'd2) / 8 > MAX_SACK_BLOCKS;
            default: return 1'b0;
        endcase
    endfunction

    function automatic opt_result_t make_rec(logic [7:0] k, logic [7:0] l, logic [31:0] v1,
                                             logic [31:0] v2, logic [1:0] bi, logic [2:0] bc);
        opt_result_t r;
        r = '0;
        r.kind = k; r.length = l; r.first_value = v1; r.second_value = v2;
        r.block_index = bi; r.block_count = bc; r.option_count = opt_cnt + 7'd1;
        return r;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        opt_result_t outs[$];
        opt_result_t st;
        logic [6:0]  lim;
        logic [7:0]  rel;
        logic [31:0] v1, v2;
        bit          done;
        lim = opt_limit > MAX_OPT_CAP ? MAX_OPT_CAP : opt_limit;
        if (!halted) begin
            if (phase == PH_KIND) begin
                if (opt_cnt >= lim || b == K_EOL) begin
                    halted = 1'b1;
                end else if (b == K_NOP) begin
                    outs.push_back(make_rec(K_NOP, 8'd1, '0, '0, 2'd0, 3'd0));
                    opt_cnt++;
                end else begin
                    cur_kind = b; cur_len = '0; byte_pos = 8'd1; acc = '0; sack_num = '0;
                    phase = PH_LEN;
                end
            end else if (phase == PH_LEN) begin
                cur_len = b;
                byte_pos = 8'd2;
                if (length_bad(cur_kind, b)) begin
                    err_flag = 1'b1; halted = 1'b1;
                end else if (b == 8'd2) begin
                    if (cur_kind != K_SACK)
                        outs.push_back(make_rec(cur_kind, 8'd2, '0, '0, 2'd0, 3'd0));
                    opt_cnt++;
                    phase = PH_KIND;
                end else begin
                    phase = PH_BODY;
                end
            end else begin
                acc = {acc[55:0], b};
                byte_pos = byte_pos + 8'd1;
                done = byte_pos == cur_len;
                rel = byte_pos - 8'd2;
                if (cur_kind == K_SACK) begin
                    if (rel[2:0] == 3'd0) begin
                        v1 = 32'((cur_len - 8'd2) >> 3);
                        outs.push_back(make_rec(K_SACK, cur_len, acc[63:32], acc[31:0],
                                                sack_num[1:0], v1[2:0]));
                        sack_num++;
                    end
                end else if (done) begin
                    v1 = '0; v2 = '0;
                    if (cur_kind == K_MSS) v1 = {16'd0, acc[15:0]};
                    else if (cur_kind == K_WS) v1 = {24'd0, acc[7:0]};
                    else if (cur_kind == K_TS) begin
                        v1 = acc[63:32]; v2 = acc[31:0];
                    end
                    outs.push_back(make_rec(cur_kind, cur_len, v1, v2, 2'd0, 3'd0));
                end
                if (done) begin
                    opt_cnt++;
                    phase = PH_KIND;
                end
            end
            if (last && !halted && phase != PH_KIND) begin
                err_flag = 1'b1; halted = 1'b1;
            end
        end
        if (last) begin
            st = '0;
            st.is_status = 1'b1; st.status_code = err_flag; st.option_count = opt_cnt;
            outs.push_back(st);
            clear_area();
        end
        if (outs.size() > 0) outs[outs.size() - 1].end_of_run = 1'b1;
        foreach (outs[i]) expected_q.push_back(outs[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_option_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b, last);
        bytes_sent++;
        if (last) areas_sent++;
    endtask

    task automatic send_area(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic write_max_options(input logic [6:0] v);
        psel <= 1; pwrite <= 1; paddr <= REG_MAX_OPTIONS; pwdata <= {25'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        opt_limit = v;
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                opt_result_t got, want;
                got = {m_is_status, m_kind, m_length, m_first_value, m_second_value,
                       m_block_index, m_block_count, m_status_code, m_option_count,
                       m_end_of_run};
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    // long receiver hold-off
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (hold_off_cycles) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // receiver ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    // one well-formed option with random content, occasionally broken
    function automatic void add_option(ref logic [7:0] a[$]);
        int   sel, n;
        sel = $urandom_range(9);
        case (sel)
            0: a.push_back(K_NOP);
            1: begin
                a.push_back(K_MSS); a.push_back(8'd4);
                a.push_back(rnd_byte()); a.push_back(rnd_byte());
            end
            2: begin a.push_back(K_WS); a.push_back(8'd3); a.push_back(rnd_byte()); end
            3: begin a.push_back(K_SACKP); a.push_back(8'd2); end
            4, 5: begin
                n = $urandom_range(MAX_SACK_BLOCKS);
                a.push_back(K_SACK); a.push_back(8'(2 + 8 * n));
                repeat (8 * n) a.push_back(rnd_byte());
            end
            6: begin a.push_back(K_TS); a.push_back(8'd10); repeat (8) a.push_back(rnd_byte()); end
            7: begin
                n = $urandom_range(6);
                a.push_back(8'($urandom_range(9, 255))); a.push_back(8'(2 + n));
                repeat (n) a.push_back(rnd_byte());
            end
            8: begin a.push_back(rnd_byte()); a.push_back(rnd_byte()); end
            default: begin
                a.push_back(8'($urandom_range(2, 8))); a.push_back(8'($urandom_range(15)));
            end
        endcase
    endfunction

    task automatic random_areas(input int n_bytes);
        logic [7:0] a[$];
        int         target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            a.delete();
            repeat ($urandom_range(1, 5)) add_option(a);
            if ($urandom_range(9) == 0) a.push_back(K_EOL);
            if ($urandom_range(7) == 0) a.push_back(rnd_byte());
            if ($urandom_range(5) == 0) a = a[0:$urandom_range(a.size() - 1)];
            send_area(a);
        end
    endtask

    task automatic test_directed();
        send_area('{K_NOP, K_NOP, K_EOL, 8'hFF, 8'h00});
        send_area('{K_MSS, 8'd4, 8'hFF, 8'hFF, K_WS, 8'd3, 8'd14, K_SACKP, 8'd2});
        send_area('{K_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01});
        send_area('{K_SACK, 8'd2, K_NOP});
        send_area('{K_SACK, 8'd10, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
        send_area('{K_MSS, 8'd5, 8'h00});
        send_area('{8'hFF, 8'd1});
        send_area('{K_TS, 8'd10, 8'h00});
        send_area('{K_SACK, 8'd34});
        send_area('{8'd200, 8'd255});
        send_area('{K_EOL});
        send_area('{K_NOP});
    endtask

    task automatic test_sack_max();
        logic [7:0] a[$];
        a = '{K_SACK, 8'd34};
        repeat (32) a.push_back(rnd_byte());
        a.push_back(K_NOP);
        send_area(a);
    endtask

    task automatic test_limits();
        wait_drained();
        write_max_options(7'd0);
        send_area('{K_NOP, K_NOP});
        wait_drained();
        write_max_options(7'd127);
        send_area('{K_NOP, K_NOP, K_NOP});
        random_areas(60);
        wait_drained();
        write_max_options(7'd2);
        send_area('{K_NOP, K_SACKP, 8'd2, K_NOP, K_MSS});
        random_areas(80);
        wait_drained();
        write_max_options(7'd64);
    endtask

    task automatic test_idling();
        random_areas(250);
        send_idle_pct = 55;
        random_areas(200);
        send_idle_pct = 0; recv_stall_pct = 55;
        random_areas(200);
        send_idle_pct = 20; recv_stall_pct = 20;
        random_areas(200);
        send_idle_pct = 0; recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        s_valid <= 1'b0;
        @(posedge aclk);
        hold_off_cycles = 200;
        -> hold_go;
        random_areas(100);
    endtask

    initial begin
        opt_limit = MAX_OPT_RESET;
        clear_area();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_sack_max();
        test_limits();
        test_idling();
        test_backpressure();
        wait_drained();
        $display("sent %0d bytes in %0d areas, checked %0d results", bytes_sent, areas_sent,
                 results_seen);
        $display("covered NOP/MSS/WS/SACK/TS, malformed and truncated areas, option limits");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
